### rtl/rrva_pkg.sv
// Package for the round-robin voice allocator.
// Holds sizing constants, the sequencer state type and the voice index helper.
// Depends on nothing.
package rrva_pkg;

	// Sizing of the voice pool and the pitch map.
	localparam int NUM_VOICES  = 16;
	localparam int NUM_PITCHES = 128;
	localparam int VOICE_W     = $clog2(NUM_VOICES);
	localparam int PITCH_W     = $clog2(NUM_PITCHES);

	// Configuration port: byte addresses, one 32-bit register.
	localparam int APB_AW = 3;
	localparam logic REG_IDX_ENABLED = 1'b0;

	// Signed voice code that means "no voice" or "allocate".
	localparam logic [4:0] VOICE_NONE = 5'h1F;

	typedef logic [VOICE_W-1:0] voice_idx_t;

	// Sequencer states, one-hot.
	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_DONE = 3'b100
	} rrva_state_t;

	// Step a voice index by one, wrapping at the pool size.
	function automatic voice_idx_t voice_wrap_inc(input voice_idx_t v);
		voice_idx_t r;
		if (v == VOICE_W'(NUM_VOICES - 1)) begin
			r = '0;
		end else begin
			r = v + VOICE_W'(1);
		end
		return r;
	endfunction

endpackage

### rtl/round_robin_voice_allocator.sv
// Round-robin voice allocator: sequencer, voice scan, pitch map and APB register.
// Depends on rrva_pkg.
//
// Channel   Direction  Handshake                       Beat contents
// command   in         start high while busy low       action, pitch, velocity, voice_request
// result    out        done high for one cycle         voice
// config    in         APB write, pready always high   enabled (address 0)
//
// A beat is accepted at a clock edge with start high and busy low.
// A clear, a disabled beat or a beat with an explicit voice or a note-off goes
// from acceptance straight to the finishing step, which raises done; a note-on
// that allocates first scans the busy marks one voice per cycle from the pointer,
// up to the whole pool. The scan through the voice busy marks sets the longest path.
// Reset clears the busy marks, the pitch map valid bits and the pointer at once.
// The result receiver cannot stall; done lasts exactly one cycle.
module round_robin_voice_allocator (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic                          action,
	input  logic [6:0]                    pitch,
	input  logic [6:0]                    velocity,
	input  logic signed [4:0]             voice_request,
	output logic                          done,
	output logic signed [4:0]             voice,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [rrva_pkg::APB_AW-1:0]   paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);
	import rrva_pkg::*;

	rrva_state_t             state_q;
	logic                    enabled_q;
	logic [NUM_VOICES-1:0]   voice_busy_q;
	logic [NUM_PITCHES-1:0]  map_valid_q;
	voice_idx_t              map_mem [NUM_PITCHES];
	voice_idx_t              map_rd_q;
	logic                    map_vld_rd_q;
	voice_idx_t              rot_ptr_q;
	voice_idx_t              scan_idx_q;
	voice_idx_t              scan_cnt_q;
	voice_idx_t              alloc_voice_q;

	// Captured command beat.
	logic                    action_q;
	logic [6:0]              pitch_q;
	logic                    note_on_q;
	logic signed [4:0]       req_q;

	logic                    done_q;
	logic signed [4:0]       voice_q;

	logic                    accept;
	logic                    cfg_wr;
	logic                    alloc_in;
	logic                    req_alloc_q;
	logic                    pitch_ok_q;
	logic [PITCH_W-1:0]      pitch_idx_in;
	logic [PITCH_W-1:0]      pitch_idx_q;
	voice_idx_t              final_voice;
	logic signed [4:0]       result_code;

	assign accept       = start && !busy;
	assign busy         = (state_q != ST_IDLE);
	assign pitch_idx_in = PITCH_W'(pitch);
	assign pitch_idx_q  = PITCH_W'(pitch_q);
	assign pitch_ok_q   = (32'(pitch_q) < NUM_PITCHES);
	assign req_alloc_q  = (req_q == -5'sd1);

	// A beat needs the scan only when it is an enabled note-on asking for a voice.
	assign alloc_in = !action && enabled_q && (voice_request == -5'sd1) && (velocity != 7'd0);

	// Configuration register: write and read back.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign prdata = (paddr[2] == REG_IDX_ENABLED) ? {31'd0, enabled_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enabled_q <= 1'b1;
		end else if (cfg_wr && (paddr[2] == REG_IDX_ENABLED)) begin
			enabled_q <= pwdata[0];
		end
	end

	// Final voice for the finishing step, with out-of-range requests folded to voice 0.
	always_comb begin
		final_voice = '0;
		if (req_alloc_q) begin
			if (note_on_q) begin
				final_voice = alloc_voice_q;
			end else if (pitch_ok_q && map_vld_rd_q) begin
				final_voice = map_rd_q;
			end
		end else if (!req_q[4] && (32'(req_q[3:0]) < NUM_VOICES)) begin
			final_voice = VOICE_W'(req_q[3:0]);
		end
	end

	// Result code: clear gives no voice, disabled passes the request through.
	always_comb begin
		if (action_q) begin
			result_code = VOICE_NONE;
		end else if (!enabled_q) begin
			result_code = req_q;
		end else begin
			result_code = 5'(final_voice);
		end
	end

	// Capture the command beat.
	always_ff @(posedge clk) begin
		if (accept) begin
			action_q  <= action;
			pitch_q   <= pitch;
			note_on_q <= (velocity != 7'd0);
			req_q     <= voice_request;
		end
	end

	// Pitch map storage: registered read at acceptance, write at the finishing step.
	always_ff @(posedge clk) begin
		if (accept) begin
			map_rd_q <= map_mem[pitch_idx_in];
		end
		if ((state_q == ST_DONE) && !action_q && enabled_q && pitch_ok_q && note_on_q) begin
			map_mem[pitch_idx_q] <= final_voice;
		end
	end

	// Sequencer, scan unit and state updates.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			voice_busy_q  <= '0;
			map_valid_q   <= '0;
			map_vld_rd_q  <= 1'b0;
			rot_ptr_q     <= '0;
			scan_idx_q    <= '0;
			scan_cnt_q    <= '0;
			alloc_voice_q <= '0;
			done_q        <= 1'b0;
			voice_q       <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						map_vld_rd_q <= map_valid_q[pitch_idx_in];
						scan_idx_q   <= rot_ptr_q;
						scan_cnt_q   <= '0;
						state_q      <= alloc_in ? ST_SCAN : ST_DONE;
					end
				end
				ST_SCAN: begin
					// One voice checked per cycle, starting at the pointer.
					if (!voice_busy_q[scan_idx_q]) begin
						alloc_voice_q <= scan_idx_q;
						state_q       <= ST_DONE;
					end else if (scan_cnt_q == VOICE_W'(NUM_VOICES - 1)) begin
						alloc_voice_q <= rot_ptr_q;
						state_q       <= ST_DONE;
					end else begin
						scan_idx_q <= voice_wrap_inc(scan_idx_q);
						scan_cnt_q <= scan_cnt_q + VOICE_W'(1);
					end
				end
				ST_DONE: begin
					done_q  <= 1'b1;
					voice_q <= result_code;
					state_q <= ST_IDLE;
					if (action_q) begin
						voice_busy_q <= '0;
					end else if (enabled_q) begin
						voice_busy_q[final_voice] <= note_on_q;
						if (pitch_ok_q) begin
							map_valid_q[pitch_idx_q] <= note_on_q;
						end
						if (req_alloc_q && note_on_q) begin
							rot_ptr_q <= voice_wrap_inc(rot_ptr_q);
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign done  = done_q;
	assign voice = voice_q;

	// The finishing step always produces exactly one result in the next cycle.
	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE) |=> done)
		else $error("result strobe missing after finishing step");

	// A result only appears right after the finishing step.
	a_done_source: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == ST_DONE))
		else $error("result strobe without finishing step");

	// An accepted beat always keeps the block busy in the next cycle.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy)
		else $error("block not busy after accepting a beat");

	// A free voice under the scan ends the scan at once.
	a_scan_stop: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_SCAN) && !voice_busy_q[scan_idx_q]) |=> (state_q == ST_DONE))
		else $error("scan passed a free voice");

	// The scan never runs past the voice pool.
	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (32'(scan_cnt_q) < NUM_VOICES))
		else $error("scan counter beyond voice pool");

endmodule

### dv/rrva_voice_checker.sv
// Checker for the round-robin voice allocator: watches the command, result and APB channels.
// Predicts the voice of every accepted command beat and compares each result beat in order.
// Depends on rrva_pkg.
module rrva_voice_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic                          busy,
	input  logic                          action,
	input  logic [6:0]                    pitch,
	input  logic [6:0]                    velocity,
	input  logic signed [4:0]             voice_request,
	input  logic                          done,
	input  logic signed [4:0]             voice,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [rrva_pkg::APB_AW-1:0]   paddr,
	input  logic [31:0]                   pwdata,
	input  logic [31:0]                   prdata,
	input  logic                          pready,
	output int                            fault_count,
	output int                            voices_owed
);
	import rrva_pkg::*;

	localparam logic [APB_AW-1:0] ENABLE_ADDR = APB_AW'(4 * REG_IDX_ENABLED);

	// Shadow of the allocator state.
	bit [NUM_VOICES-1:0] voice_held;
	bit                  pitch_mapped [NUM_PITCHES];
	int                  pitch_voice [NUM_PITCHES];
	int                  rotor;
	logic                alloc_on;

	// Voices expected on the result channel, oldest first.
	logic signed [4:0]   voices_due [$];
	logic signed [4:0]   want;
	int                  faults = 0;
	int                  owed = 0;

	assign fault_count = faults;
	assign voices_owed = owed;

	task automatic log_fault(input string what);
		$display("[%0t] voice allocator mismatch: %s", $time, what);
		faults++;
	endtask

	// Work out the voice for one command beat and update the shadow state.
	function automatic logic signed [4:0] assign_voice(input logic act, input logic [6:0] p,
			input logic [6:0] vel, input logic signed [4:0] req);
		int  v;
		bit  found;
		bit  note_on;
		if (act) begin
			voice_held = '0;
			return VOICE_NONE;
		end
		if (!alloc_on) begin
			return req;
		end
		note_on = (vel != 0);
		if (req == -1) begin
			if (note_on) begin
				// Search for a free voice from the pointer; steal at the pointer if none.
				v = rotor;
				found = 1'b0;
				for (int i = 0; i < NUM_VOICES; i++) begin
					if (!found && !voice_held[(rotor + i) % NUM_VOICES]) begin
						v = (rotor + i) % NUM_VOICES;
						found = 1'b1;
					end
				end
				rotor = (rotor + 1) % NUM_VOICES;
			end else if (p < NUM_PITCHES && pitch_mapped[p]) begin
				v = pitch_voice[p];
			end else begin
				v = 0;
			end
		end else if (req < 0) begin
			v = 0;
		end else begin
			v = req;
		end
		if (v >= NUM_VOICES) begin
			v = 0;
		end
		voice_held[v] = note_on;
		if (p < NUM_PITCHES) begin
			pitch_mapped[p] = note_on;
			pitch_voice[p] = note_on ? v : 0;
		end
		return 5'(v);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			voice_held = '0;
			for (int i = 0; i < NUM_PITCHES; i++) begin
				pitch_mapped[i] = 1'b0;
				pitch_voice[i] = 0;
			end
			rotor = 0;
			alloc_on = 1'b1;
			voices_due.delete();
			owed = 0;
		end else begin
			// Register access: track writes, check read data.
			if (psel && penable && pready && paddr == ENABLE_ADDR) begin
				if (pwrite) begin
					alloc_on = pwdata[0];
				end else if (prdata !== {31'b0, alloc_on}) begin
					log_fault($sformatf("enabled reads 0x%08h, expected %0d", prdata, alloc_on));
				end
			end

			// A result beat retires the oldest expectation.
			if (done) begin
				if (voices_due.size() == 0) begin
					log_fault($sformatf("result beat voice %0d with nothing outstanding", voice));
				end else begin
					want = voices_due.pop_front();
					if (voice !== want) begin
						log_fault($sformatf("voice %0d, expected %0d", voice, want));
					end
				end
			end

			// An accepted command beat adds one expectation.
			if (start && !busy) begin
				voices_due.push_back(assign_voice(action, pitch, velocity, voice_request));
			end
			owed = voices_due.size();
		end
	end

endmodule

### dv/tb_round_robin_voice_allocator.sv
// Testbench top for the round-robin voice allocator: clock, reset, command and APB stimulus.
// Instantiates the block and rrva_voice_checker, and prints the verdict.
// Depends on rrva_pkg, round_robin_voice_allocator and rrva_voice_checker.
module tb_round_robin_voice_allocator;
	import rrva_pkg::*;

	localparam logic [APB_AW-1:0] ENABLE_ADDR = APB_AW'(4 * REG_IDX_ENABLED);

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 start;
	logic                 busy;
	logic                 action;
	logic [6:0]           pitch;
	logic [6:0]           velocity;
	logic signed [4:0]    voice_request;
	logic                 done;
	logic signed [4:0]    voice;
	logic                 psel;
	logic                 penable;
	logic                 pwrite;
	logic [APB_AW-1:0]    paddr;
	logic [31:0]          pwdata;
	logic [31:0]          prdata;
	logic                 pready;
	int                   fault_count;
	int                   voices_owed;

	// Chance in a hundred that the sender pauses before a beat.
	int                   idle_pct = 0;
	// Pitches currently sounding, used to aim note-offs at mapped pitches.
	int                   sounding [$];

	// Random phases: allocation setting, sender idling and beat count.
	int                   phase_alloc [6] = '{1, 1, 0, 1, 0, 1};
	int                   phase_idle [6]  = '{0, 53, 7, 7, 0, 53};
	int                   phase_beats [6] = '{200, 200, 150, 200, 150, 200};

	always #4 clk = ~clk;

	round_robin_voice_allocator uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.action        (action),
		.pitch         (pitch),
		.velocity      (velocity),
		.voice_request (voice_request),
		.done          (done),
		.voice         (voice),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready)
	);

	rrva_voice_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.action        (action),
		.pitch         (pitch),
		.velocity      (velocity),
		.voice_request (voice_request),
		.done          (done),
		.voice         (voice),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.fault_count   (fault_count),
		.voices_owed   (voices_owed)
	);

	// Offer one command beat and hold it until the block takes it.
	task automatic send_beat(input logic a, input logic [6:0] p, input logic [6:0] vel,
			input logic signed [4:0] req);
		if ($urandom_range(99) < idle_pct) begin
			start = 1'b0;
			repeat ($urandom_range(1, 12)) @(negedge clk);
		end
		action = a;
		pitch = p;
		velocity = vel;
		voice_request = req;
		start = 1'b1;
		@(posedge clk);
		while (busy) @(posedge clk);
		@(negedge clk);
	endtask

	// Stop offering beats and wait until every result beat has come back.
	task automatic settle();
		start = 1'b0;
		while (voices_owed != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// Write the enabled register, then read it back for the checker.
	task automatic set_enabled(input logic val);
		psel = 1'b1;
		pwrite = 1'b1;
		paddr = ENABLE_ADDR;
		pwdata = {16'($urandom_range(32'hFFFF)), 15'($urandom_range(32'h7FFF)), val};
		penable = 1'b0;
		@(negedge clk);
		penable = 1'b1;
		@(negedge clk);
		pwrite = 1'b0;
		penable = 1'b0;
		@(negedge clk);
		penable = 1'b1;
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		@(negedge clk);
	endtask

	// One random command beat, mostly well-formed note traffic.
	task automatic random_beat();
		int          pick;
		int          slot;
		logic [6:0]  p;
		logic [6:0]  vel;
		pick = $urandom_range(99);
		if (pick < 3) begin
			send_beat(1'b1, 7'($urandom), 7'($urandom), 5'($urandom));
		end else if (pick < 45) begin
			// Note-on that asks for allocation, mostly on a small set of pitches.
			p = ($urandom_range(3) == 0) ? 7'($urandom_range(127)) : 7'($urandom_range(23));
			sounding.push_back(p);
			send_beat(1'b0, p, 7'($urandom_range(1, 127)), VOICE_NONE);
		end else if (pick < 75) begin
			// Note-off looked up by pitch.
			if (sounding.size() > 0) begin
				slot = $urandom_range(sounding.size() - 1);
				p = 7'(sounding[slot]);
				sounding.delete(slot);
			end else begin
				p = 7'($urandom_range(127));
			end
			send_beat(1'b0, p, 7'd0, VOICE_NONE);
		end else if (pick < 90) begin
			// Explicit voice request, any 5-bit code.
			p = 7'($urandom_range(127));
			vel = ($urandom_range(3) == 0) ? 7'd0 : 7'($urandom_range(127));
			if (vel != 0) begin
				sounding.push_back(p);
			end
			send_beat(1'b0, p, vel, 5'($urandom_range(31)));
		end else begin
			send_beat(1'b0, 7'($urandom), 7'($urandom), 5'($urandom));
		end
		if (sounding.size() > 64) begin
			sounding.delete(0);
		end
	endtask

	// Run limit.
	initial begin
		#2000000;
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		action = 1'b0;
		pitch = '0;
		velocity = '0;
		voice_request = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: fill every voice by allocation, then steal one.
		set_enabled(1'b1);
		for (int i = 0; i < NUM_VOICES; i++) begin
			send_beat(1'b0, (i == NUM_VOICES - 1) ? 7'd127 : 7'(i * 8),
				(i == 0) ? 7'd127 : (i == 1) ? 7'd1 : 7'($urandom_range(1, 127)), VOICE_NONE);
		end
		send_beat(1'b0, 7'd50, 7'd64, VOICE_NONE);

		// Directed: note-off by mapped and unmapped pitch, explicit and odd requests, clear.
		send_beat(1'b0, 7'd8, 7'd0, VOICE_NONE);
		send_beat(1'b0, 7'd3, 7'd0, VOICE_NONE);
		send_beat(1'b0, 7'd9, 7'd100, 5'sd15);
		send_beat(1'b0, 7'd127, 7'd0, -5'sd16);
		send_beat(1'b0, 7'd20, 7'd5, -5'sd2);
		send_beat(1'b1, 7'd0, 7'd0, 5'sd0);

		// Directed: requests pass through while allocation is off; clear still answers.
		settle();
		set_enabled(1'b0);
		send_beat(1'b0, 7'd40, 7'd30, VOICE_NONE);
		send_beat(1'b0, 7'd41, 7'd0, -5'sd16);
		send_beat(1'b0, 7'd42, 7'd99, 5'sd15);
		send_beat(1'b1, 7'd43, 7'd1, 5'sd7);

		// Random phases with different settings and sender idling.
		for (int ph = 0; ph < 6; ph++) begin
			settle();
			set_enabled(phase_alloc[ph][0]);
			idle_pct = phase_idle[ph];
			for (int n = 0; n < phase_beats[ph]; n++) begin
				random_beat();
			end
		end

		settle();
		if (fault_count == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
